// ===== rtl/dq_pkg.sv =====
// Package for the double-ended queue: item types, operation and status codes.
package dq_pkg;

	// Default number of entries held in the ring.
	localparam int unsigned CAPACITY_DEFAULT = 16;

	// Operation codes of an input item.
	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// One input item.
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
	} cmd_item_t;

	// One result item.
	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} rsp_item_t;

endpackage

// ===== rtl/dq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
module dq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered: data available in the cycle after the address.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of signed 32-bit words held in a ring buffer RAM.
//
// Input channel cmd (cmd_valid, cmd_stall, cmd): each item is a push at the
// front, a push at the back, a pop from the front or a pop from the back.
// Output channel rsp (rsp_valid, rsp_stall, rsp): exactly one result item per
// input item, in order, carrying the popped word, a status and the count of
// entries held after the step.
// A push, a rejected push (overflow) and a pop from an empty queue have their
// result registered at the edge that accepts the item.
// A successful pop takes its word from the entry RAM: the RAM read register,
// then the result register; cmd_stall is held high during the read.
// Sustained rate: one item per cycle for pushes while rsp_stall is low.
// The result register parts the two channels: a new item is taken in the
// same cycle as the waiting result is taken. While rsp_stall is high and a
// result waits, cmd_stall is high.
// Reset empties the queue (front index and count cleared); the RAM contents
// are left as they are and are only read at positions written by a push.
module double_ended_queue_top #(
	parameter int unsigned CAPACITY = dq_pkg::CAPACITY_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  dq_pkg::cmd_item_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dq_pkg::rsp_item_t rsp
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = IDX_W + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	dq_pkg::rsp_item_t rsp_q;

	logic             rsp_free;
	logic             cmd_take;
	logic             is_push;
	logic             is_front;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] head_prev;
	logic [IDX_W-1:0] head_next;
	logic [SUM_W-1:0] back_sum;
	logic [SUM_W-1:0] back_wrap;
	logic [IDX_W-1:0] back_pos;
	logic [CNT_W-1:0] back_off;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;

	// Handshake: an item is taken when no pop read is pending and the result
	// register is empty or being emptied.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q == S_READ) || !rsp_free;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_push  = !cmd.mode[1];
	assign is_front = (cmd.mode == dq_pkg::OP_PUSH_FRONT) ||
	                  (cmd.mode == dq_pkg::OP_POP_FRONT);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// Ring position arithmetic around the front index.
	assign head_prev = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
	assign head_next = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	// Back position: front plus count for a push, plus count minus one for a pop.
	assign back_off  = is_push ? count_q : count_q - 1'b1;
	assign back_sum  = SUM_W'(head_q) + SUM_W'(back_off);
	assign back_wrap = back_sum - SUM_W'(CAPACITY);
	assign back_pos  = (back_sum >= SUM_W'(CAPACITY)) ? back_wrap[IDX_W-1:0]
	                                                  : back_sum[IDX_W-1:0];

	// RAM accesses: pushes into a queue with room write, successful pops read.
	assign ram_we    = cmd_take && is_push && !full;
	assign ram_waddr = is_front ? head_prev : back_pos;
	assign ram_re    = cmd_take && !is_push && !empty;
	assign ram_raddr = is_front ? head_q : back_pos;

	dq_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Queue state and sequencing of pop reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ram_we) begin
						count_q <= count_q + 1'b1;
						if (is_front) begin
							head_q <= head_prev;
						end
					end else if (ram_re) begin
						count_q <= count_q - 1'b1;
						state_q <= S_READ;
						if (is_front) begin
							head_q <= head_next;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((cmd_take && !ram_re) || (state_q == S_READ)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload: immediate for pushes and failed pops, from the RAM for pops.
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rsp_q.popped_value <= ram_rdata;
			rsp_q.status       <= dq_pkg::ST_OK;
			rsp_q.occupancy    <= 5'(count_q);
		end else if (cmd_take && !ram_re) begin
			rsp_q.popped_value <= '0;
			if (is_push && full) begin
				rsp_q.status    <= dq_pkg::ST_OVERFLOW;
				rsp_q.occupancy <= 5'(count_q);
			end else if (!is_push) begin
				rsp_q.status    <= dq_pkg::ST_UNDERFLOW;
				rsp_q.occupancy <= 5'(count_q);
			end else begin
				rsp_q.status    <= dq_pkg::ST_OK;
				rsp_q.occupancy <= 5'(count_q + 1'b1);
			end
		end
	end

	// The count never goes beyond the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// The front index always names a ring position.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(CAPACITY - 1))
		else $error("front index outside the ring");

	// A RAM read is always followed by a result built from its data.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (state_q == S_READ) ##1 rsp_valid_q)
		else $error("pop read did not produce a result");

	// No item is taken while a pop read is pending.
	a_read_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !cmd_take)
		else $error("item accepted during a pop read");

	// A waiting result is never overwritten before it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled result changed");

endmodule
